@@ hdl/dpbc_pkg.sv @@
// Package for the dual-polarization baseline correlator.
// Holds shared types and constants; no dependencies.
package dpbc_pkg;

   localparam int SUM_BITS = 49;
   localparam int VIS_BITS = 33;
   localparam int CNT_BITS = 17;
   localparam int NUM_SUMS = 8;

   // Work handed from the front (accumulate) to the back (divide).
   typedef struct packed {
      logic [NUM_SUMS-1:0][SUM_BITS-1:0] sums;
      logic [CNT_BITS-1:0]               count;
   } job_type;

endpackage

@@ hdl/dpbc_front.sv @@
// Front part: multiplies, accumulates and counts samples; hands a job at the end of a run.
// Depends on dpbc_pkg.
module dpbc_front #(
   parameter int SAMPLE_BITS     = 16,
   parameter int MAX_INTEGRATION = 65536
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  single_channel_mode,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [8*16-1:0]       in_samples,
   input  logic                  flag_one,
   input  logic                  flag_two,
   input  logic                  last_sample,
   input  logic [11:0]           channel_index,
   output logic                  job_valid,
   input  logic                  job_ready,
   output dpbc_pkg::job_type     job
);
   import dpbc_pkg::*;

   localparam int PROD_BITS = 2*SAMPLE_BITS + 1;

   logic signed [SAMPLE_BITS-1:0] s_ff [8];
   logic                          p_valid_ff, p_cnt_ff, p_last_ff, p_blank_ff;
   logic signed [PROD_BITS-1:0]   prod_ff [8];
   logic [NUM_SUMS-1:0][SUM_BITS-1:0] acc_ff;
   logic [CNT_BITS-1:0]           cnt_ff;
   logic                          job_valid_ff;
   job_type                       job_ff;
   logic                          s_valid_ff, s_cnt_ff, s_last_ff, s_blank_ff;
   logic [NUM_SUMS-1:0][SUM_BITS-1:0] acc_in;
   logic [CNT_BITS-1:0]           cnt_in;
   logic                          stall;

   // Stall the whole pipe only when a finished run cannot be handed off.
   assign stall    = job_valid_ff && !job_ready && p_valid_ff && p_last_ff;
   assign in_ready = !stall;
   assign job_valid = job_valid_ff;
   assign job       = job_ff;

   // Stage one: capture samples.
   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (!stall) begin
         s_valid_ff <= in_valid;
      end
      if (!stall && in_valid) begin
         for (int i = 0; i < 8; i++) begin
            s_ff[i] <= signed'(in_samples[16*i +: SAMPLE_BITS]);
         end
         s_cnt_ff   <= !flag_one && !flag_two;
         s_last_ff  <= last_sample;
         s_blank_ff <= !single_channel_mode && (channel_index == '0);
      end
   end

   // Stage two: the eight cross products, conjugating station two.
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (!stall) begin
         p_valid_ff <= s_valid_ff;
      end
      if (!stall) begin
         p_cnt_ff   <= s_cnt_ff;
         p_last_ff  <= s_last_ff;
         p_blank_ff <= s_blank_ff;
         for (int a = 0; a < 2; a++) begin
            for (int b = 0; b < 2; b++) begin
               prod_ff[4*a+2*b] <= PROD_BITS'(s_ff[2*a]*s_ff[4+2*b])
                  + PROD_BITS'(s_ff[2*a+1]*s_ff[4+2*b+1]);
               prod_ff[4*a+2*b+1] <= PROD_BITS'(s_ff[2*a+1]*s_ff[4+2*b])
                  - PROD_BITS'(s_ff[2*a]*s_ff[4+2*b+1]);
            end
         end
      end
   end

   // Accumulate sums and the unflagged count.
   always_comb begin
      for (int i = 0; i < NUM_SUMS; i++) begin
         acc_in[i] = acc_ff[i] + SUM_BITS'(prod_ff[i]);
      end
      cnt_in = cnt_ff;
      if (p_cnt_ff && cnt_ff < CNT_BITS'(MAX_INTEGRATION)) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         job_valid_ff <= 1'b0;
      end else begin
         if (job_valid_ff && job_ready) begin
            job_valid_ff <= 1'b0;
         end
         if (p_valid_ff && !stall) begin
            if (p_last_ff) begin
               acc_ff       <= '0;
               cnt_ff       <= '0;
               job_valid_ff <= 1'b1;
            end else begin
               acc_ff <= acc_in;
               cnt_ff <= cnt_in;
            end
         end
      end
      if (p_valid_ff && !stall && p_last_ff) begin
         job_ff.sums  <= acc_in;
         job_ff.count <= p_blank_ff ? '0 : cnt_in;
      end
   end

`ifndef SYNTH
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      stall |=> p_valid_ff && p_last_ff)
      else $error("stall dropped the finished run");
   a_job_kept: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff && !job_ready |=> job_valid_ff && $stable(job_ff))
      else $error("job changed while waiting");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(MAX_INTEGRATION))
      else $error("count past limit");
`endif
endmodule

@@ hdl/dpbc_back.sv @@
// Back part: divides the eight sums by the count with a shared restoring divider.
// Depends on dpbc_pkg.
module dpbc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   output logic                  job_ready,
   input  dpbc_pkg::job_type     job,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [8*33-1:0]       out_vis,
   output logic [16:0]           out_count
);
   import dpbc_pkg::*;

   localparam int MAG_BITS = SUM_BITS - 1;
   localparam int BIT_W    = $clog2(SUM_BITS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_OUT  = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   job_type              job_ff;
   logic [2:0]           idx_ff;
   logic [BIT_W-1:0]     bit_ff;
   logic [SUM_BITS-1:0]  num_ff;
   logic [CNT_BITS-1:0]  rem_ff;
   logic                 neg_ff;
   logic [NUM_SUMS-1:0][VIS_BITS-1:0] vis_ff;
   logic [SUM_BITS-1:0]  sel_sum, mag;
   logic [CNT_BITS:0]    trial;
   logic [SUM_BITS-1:0]  qmag;
   logic [VIS_BITS-1:0]  vis_val;

   assign job_ready = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_OUT);
   assign out_vis   = vis_ff;
   assign out_count = job_ff.count;

   assign sel_sum = job_ff.sums[idx_ff];
   assign mag     = sel_sum[SUM_BITS-1] ? SUM_BITS'(-sel_sum) : sel_sum;
   assign trial   = {rem_ff, num_ff[SUM_BITS-1]} - {1'b0, job_ff.count};

   // Saturate the quotient magnitude to 2^31 and apply the sign.
   always_comb begin
      qmag = {num_ff[SUM_BITS-2:0], ~trial[CNT_BITS]};
      if (qmag > SUM_BITS'(33'h0_8000_0000)) begin
         qmag = SUM_BITS'(33'h0_8000_0000);
      end
      vis_val = neg_ff ? VIS_BITS'(-qmag) : VIS_BITS'(qmag);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (job_valid) state_in = ST_DIV;
         ST_DIV:  if (bit_ff == '0 && idx_ff == 3'd7) state_in = ST_OUT;
         ST_OUT:  if (out_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // One quotient bit per cycle, eight sums in turn.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      unique case (state_ff)
         ST_IDLE: begin
            job_ff <= job;
            idx_ff <= '0;
            bit_ff <= BIT_W'(SUM_BITS);
         end
         ST_DIV: begin
            if (bit_ff == BIT_W'(SUM_BITS)) begin
               num_ff <= {1'b0, mag[MAG_BITS-1:0]} | {mag[SUM_BITS-1], {MAG_BITS{1'b0}}};
               rem_ff <= '0;
               neg_ff <= sel_sum[SUM_BITS-1];
               bit_ff <= BIT_W'(SUM_BITS - 1);
            end else begin
               num_ff <= {num_ff[SUM_BITS-2:0], ~trial[CNT_BITS]};
               rem_ff <= trial[CNT_BITS] ? {rem_ff[CNT_BITS-2:0], num_ff[SUM_BITS-1]}
                                         : trial[CNT_BITS-1:0];
               if (bit_ff == '0) begin
                  vis_ff[idx_ff] <= (job_ff.count == '0) ? '0 : vis_val;
                  idx_ff <= idx_ff + 1'b1;
                  bit_ff <= BIT_W'(SUM_BITS);
               end else begin
                  bit_ff <= bit_ff - 1'b1;
               end
            end
         end
         ST_OUT: ;
         default: ;
      endcase
   end

`ifndef SYNTH
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_vis))
      else $error("result changed while stalled");
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !job_ready)
      else $error("job taken while busy");
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state not one-hot");
`endif
endmodule

@@ hdl/dual_pol_baseline_correlator.sv @@
// Top level of the dual-polarization baseline correlator.
// Depends on dpbc_pkg, dpbc_front and dpbc_back.
//
// Takes one sample per clock while the input is not stalled and accumulates
// the four complex cross products of one baseline in a three-stage front
// pipeline. On the last sample of a run the sums go to a back unit that
// divides them one quotient bit per cycle: each of the eight sums in turn
// gets a setup step that loads its magnitude and sign, then its quotient
// bits. While the back unit is busy, one further finished run waits in the
// hand-off register; the run end after that stalls the input. Samples within
// a run flow at one per clock. Output is held until taken.
module dual_pol_baseline_correlator #(
   parameter int SAMPLE_BITS     = 16,
   parameter int MAX_INTEGRATION = 65536
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic          csr_data,      // single_channel_mode
   input  logic          req_tvalid,
   output logic          req_tready,
   // x1_re, x1_im, y1_re, y1_im, x2_re, x2_im, y2_re, y2_im, flag_one, flag_two,
   // channel_index (low bit first), zero fill
   input  logic [143:0]  req_tdata,
   input  logic          req_tlast,     // last_sample
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // xx_re, xx_im, xy_re, xy_im, yx_re, yx_im, yy_re, yy_im, valid_count, zero fill
   output logic [287:0]  rsp_tdata
);
   import dpbc_pkg::*;

   logic    mode_ff;
   logic    job_valid, job_ready;
   job_type job;
   logic [8*VIS_BITS-1:0] vis;
   logic [CNT_BITS-1:0]   cnt;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_valid) begin
         mode_ff <= csr_data;
      end
   end

   dpbc_front #(.SAMPLE_BITS(SAMPLE_BITS), .MAX_INTEGRATION(MAX_INTEGRATION)) u_front (
      .clock, .reset,
      .single_channel_mode(mode_ff),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_samples(req_tdata[127:0]),
      .flag_one(req_tdata[128]), .flag_two(req_tdata[129]),
      .last_sample(req_tlast), .channel_index(req_tdata[141:130]),
      .job_valid, .job_ready, .job
   );

   dpbc_back u_back (
      .clock, .reset, .job_valid, .job_ready, .job,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_vis(vis), .out_count(cnt)
   );

   assign rsp_tdata = {7'b0, cnt, vis};
endmodule

@@ dv/tb_dual_pol_baseline_correlator.sv @@
// Self-checking testbench for the dual-polarization baseline correlator.
// Depends on dpbc_pkg and the RTL under hdl; predicts each visibility item
// from the accepted samples and compares it with the block's output items.
module tb_dual_pol_baseline_correlator;
   import dpbc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int  MAX_INTEG   = 65536;
   localparam int  LIMIT       = 3000000;
   localparam int  DRAIN_WAIT  = 500;
   localparam int  LONG_RUN    = 40;
   localparam int  MAX_REPORTS = 10;

   // One time sample as the sender sees it.
   typedef struct {
      logic [7:0][15:0] smp;     // x1_re, x1_im, y1_re, y1_im, x2_re, x2_im, y2_re, y2_im
      logic             flag1;
      logic             flag2;
      logic             last;
      logic [11:0]      chan;
   } sample_type;

   // One visibility item.
   typedef struct {
      logic [7:0][VIS_BITS-1:0] vis;
      logic [CNT_BITS-1:0]      cnt;
   } vis_type;

   // Accumulates samples and keeps the queue of expected visibility items.
   class visibility_scoreboard;
      logic [SUM_BITS-1:0] sums [8];
      int unsigned         unflagged;
      bit                  single_chan;
      vis_type             pending [$];
      int                  errors;

      function new();
         foreach (sums[i]) sums[i] = '0;
         unflagged   = 0;
         single_chan = 0;
         errors      = 0;
      endfunction

      function void note_sample(sample_type s);
         longint v [8];
         longint p [8];
         longint q;
         longint sv;
         int unsigned cnt;
         vis_type e;
         foreach (v[i]) v[i] = longint'($signed(s.smp[i]));
         // Station one times the conjugate of station two.
         p[0] = v[0] * v[4] + v[1] * v[5];
         p[1] = v[1] * v[4] - v[0] * v[5];
         p[2] = v[0] * v[6] + v[1] * v[7];
         p[3] = v[1] * v[6] - v[0] * v[7];
         p[4] = v[2] * v[4] + v[3] * v[5];
         p[5] = v[3] * v[4] - v[2] * v[5];
         p[6] = v[2] * v[6] + v[3] * v[7];
         p[7] = v[3] * v[6] - v[2] * v[7];
         foreach (sums[i]) sums[i] = sums[i] + p[i][SUM_BITS-1:0];
         if (!s.flag1 && !s.flag2 && unflagged < MAX_INTEG) unflagged++;
         if (!s.last) return;
         // Channel zero is blanked unless the block runs a single channel.
         cnt = (!single_chan && s.chan == 0) ? 0 : unflagged;
         for (int i = 0; i < 8; i++) begin
            q = 0;
            if (cnt != 0) begin
               sv = longint'($signed(sums[i]));
               q = sv / longint'(cnt);
               if (q > 64'sd2147483648) q = 64'sd2147483648;
               if (q < -64'sd2147483648) q = -64'sd2147483648;
            end
            e.vis[i] = q[VIS_BITS-1:0];
         end
         e.cnt = cnt[CNT_BITS-1:0];
         pending.push_back(e);
         foreach (sums[i]) sums[i] = '0;
         unflagged = 0;
      endfunction

      function void check_visibility(logic [287:0] data);
         vis_type e;
         logic [VIS_BITS-1:0] got;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) $display("Unexpected visibility item: %h", data);
            return;
         end
         e = pending.pop_front();
         for (int i = 0; i < 8; i++) begin
            got = data[i*VIS_BITS +: VIS_BITS];
            if (got !== e.vis[i]) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("Visibility %0d mismatch: expected %h, got %h", i, e.vis[i], got);
            end
         end
         if (data[8*VIS_BITS +: CNT_BITS] !== e.cnt) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("Valid count mismatch: expected %0d, got %0d",
                        e.cnt, data[8*VIS_BITS +: CNT_BITS]);
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic         csr_data = 0;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic         req_tlast = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [287:0] rsp_tdata;

   visibility_scoreboard sb = new();
   int  cycles = 0;
   bit  burst = 0;        // when set, neither side idles
   bit  long_hold = 0;    // receiver holds off for a long stretch once

   dual_pol_baseline_correlator dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #2 clock = ~clock;

   // Watchdog on the cycle count.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int draw_gap();
      return burst ? 0 : $urandom_range(9);
   endfunction

   function automatic logic [15:0] draw_value();
      logic [15:0] corner [4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
      if ($urandom_range(7) == 0) return corner[$urandom_range(3)];
      return 16'($urandom());
   endfunction

   function automatic sample_type random_sample(logic last);
      sample_type s;
      foreach (s.smp[i]) s.smp[i] = draw_value();
      s.flag1 = ($urandom_range(9) == 0);
      s.flag2 = ($urandom_range(9) == 0);
      s.last  = last;
      s.chan  = ($urandom_range(3) == 0) ? 12'd0 : 12'($urandom());
      return s;
   endfunction

   // Offers one sample after a gap and waits until it is taken.
   task automatic send_sample(sample_type s, int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {2'd0, s.chan, s.flag2, s.flag1, s.smp};
      req_tlast  <= s.last;
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_sample(s);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_tvalid <= 0;
   endtask

   task automatic wait_idle();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_mode(logic mode);
      @(negedge clock);
      csr_data  <= mode;
      csr_valid <= 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.single_chan = mode;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // Sends a random phase made of short runs; the last sample closes a run.
   task automatic random_phase(int n, bit pause_mid);
      sample_type s;
      int left = 0;
      for (int k = 0; k < n; k++) begin
         if (left == 0) left = ($urandom_range(9) == 0) ? $urandom_range(40, 80)
                                                         : $urandom_range(1, 16);
         left--;
         s = random_sample(left == 0 || k == n - 1);
         if ($urandom_range(19) == 0) s.last = ~s.last;  // broken run lengths
         if (k == n - 1) s.last = 1;
         if (s.last) left = 0;
         send_sample(s, draw_gap());
         if (pause_mid && k == n / 2) begin
            stop_sending();
            while (sb.pending.size() != 0) @(negedge clock);
         end
      end
      stop_sending();
   endtask

   // Receiver: random gaps per item, one long hold-off when asked.
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      rsp_tready <= 1;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            sb.check_visibility(rsp_tdata);
            gap = draw_gap();
            if (long_hold) begin
               long_hold = 0;
               gap = 3000;
            end
            if (gap > 0) begin
               @(negedge clock);
               rsp_tready <= 0;
               repeat (gap) @(negedge clock);
               rsp_tready <= 1;
            end
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      sample_type s;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed part in multi-channel mode.
      write_mode(0);
      s = random_sample(1);
      s.smp = {8{16'h8000}}; s.flag1 = 0; s.flag2 = 0; s.chan = 12'd5;
      send_sample(s, 0);                              // single-sample run, most negative
      s.smp = {8{16'h7fff}}; s.chan = 12'hfff;
      send_sample(s, 0);                              // most positive
      s.smp = {{4{16'h7fff}}, {4{16'h8000}}};
      send_sample(s, 2);                              // mixed signs
      s.chan = 12'd0;
      send_sample(s, 0);                              // channel zero is blanked
      for (int k = 0; k < 4; k++) begin              // all flag combinations
         s = random_sample(0);
         s.flag1 = k[0]; s.flag2 = k[1];
         send_sample(s, 1);
      end
      for (int k = 0; k < 3; k++) begin              // every sample flagged
         s = random_sample(k == 2);
         s.flag1 = 1;
         if (s.last) s.chan = 12'd7;
         send_sample(s, 0);
      end
      stop_sending();
      wait_idle();

      // Single-channel mode: channel zero is valid; then a back-to-back run
      // of most negative samples builds large sums.
      write_mode(1);
      s = random_sample(1);
      s.chan = 12'd0; s.flag1 = 0; s.flag2 = 0;
      send_sample(s, 0);
      burst = 1;
      s.smp = {8{16'h8000}};
      for (int k = 0; k < LONG_RUN; k++) begin
         s.last = (k == LONG_RUN - 1);
         send_sample(s, 0);
      end
      stop_sending();
      burst = 0;
      wait_idle();

      // Random phases with changing settings.
      for (int ph = 0; ph < 6; ph++) begin
         write_mode(ph[0]);
         burst = (ph == 2);
         if (ph == 3) long_hold = 1;
         random_phase(300, ph == 4);
         burst = 0;
         wait_idle();
      end

      repeat (DRAIN_WAIT) @(negedge clock);
      if (sb.pending.size() != 0) begin
         sb.errors++;
         $display("%0d visibility items never arrived", sb.pending.size());
      end
      if (sb.errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule

@@ sim.f @@
hdl/dpbc_pkg.sv
hdl/dpbc_front.sv
hdl/dpbc_back.sv
hdl/dual_pol_baseline_correlator.sv
dv/tb_dual_pol_baseline_correlator.sv
